/* rtl/core/sts_pkg.sv */
// shared types and codes for the sleep-tick thread scheduler
`timescale 1ns / 1ps
package sts_pkg;

	localparam int REQ_W      = 3;
	localparam int TICKS_W    = 16;
	localparam int QSLOT_W    = 4;
	localparam int SLOT_OUT_W = 4;
	localparam int STAT_W     = 2;
	localparam int SSTATE_W   = 2;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_TICK   = 3'd0,
		REQ_CREATE = 3'd1,
		REQ_SLEEP  = 3'd2,
		REQ_EXIT   = 3'd3,
		REQ_QUERY  = 3'd4
	} req_t;

	// slot states
	typedef enum logic [SSTATE_W-1:0] {
		SL_EMPTY = 2'd0,
		SL_READY = 2'd1,
		SL_SLEEP = 2'd2
	} slot_st_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NOCUR = 2'd2
	} stat_t;

	// one slot table entry as stored in memory
	typedef struct packed {
		slot_st_t           st;
		logic [TICKS_W-1:0] left;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_QUERY,
		S_DRAIN,
		S_RESOLVE
	} fsm_t;

endpackage

/* rtl/core/sts_req_if.sv */
// request channel: valid/ready handshake with request payload
`timescale 1ns / 1ps
interface sts_req_if;
	logic                        valid;
	logic                        ready;
	logic [sts_pkg::REQ_W-1:0]   req_type;
	logic [sts_pkg::TICKS_W-1:0] sleep_ticks;
	logic [sts_pkg::QSLOT_W-1:0] query_slot;

	modport source (output valid, output req_type, output sleep_ticks, output query_slot,
		input ready);
	modport sink (input valid, input req_type, input sleep_ticks, input query_slot,
		output ready);
endinterface

/* rtl/core/sts_rsp_if.sv */
// result channel: valid/ready handshake with result payload
`timescale 1ns / 1ps
interface sts_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [sts_pkg::SLOT_OUT_W-1:0] result_slot;
	logic                           switched;
	logic [sts_pkg::STAT_W-1:0]     status;
	logic [sts_pkg::SSTATE_W-1:0]   slot_state;
	logic [sts_pkg::SLOT_OUT_W-1:0] current_out;

	modport source (output valid, output result_slot, output switched, output status,
		output slot_state, output current_out, input ready);
	modport sink (input valid, input result_slot, input switched, input status,
		input slot_state, input current_out, output ready);
endinterface

/* rtl/core/sts_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module sts_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/core/sleep_tick_thread_scheduler_core.sv */
// top level of the sleep-tick thread scheduler: slot table sweep and result register
`timescale 1ns / 1ps
//
//  channel  dir  beat contents                                  handshake
//  -------  ---  ---------------------------------------------  ---------
//  req      in   req_type, sleep_ticks, query_slot              valid/ready
//  rsp      out  result_slot, switched, status, slot_state,     valid/ready
//                current_out
//
//  one request at a time. tick and create sweep slots 1..NUM_SLOTS-1 through the
//  single read port of the slot ram, then drain and resolve before the next accept.
//  query reads one slot, then drains and resolves; sleep, exit and unknown codes go straight to resolve.
//  reset clears the per-slot valid bits at once, so an unwritten slot reads as
//  empty with a zero countdown; no clearing pass is needed.
//  a result waiting on rsp holds the sequencer in its resolve step; req.ready is
//  high only while the sequencer is idle.
module sleep_tick_thread_scheduler_core #(
	parameter int NUM_SLOTS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	sts_req_if.sink   req,
	sts_rsp_if.source rsp
);
	import sts_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);

	// sequencer
	fsm_t state_q, state_d;

	// captured request
	logic [REQ_W-1:0]   req_q;
	logic [TICKS_W-1:0] ticks_q;
	logic [QSLOT_W-1:0] qs_q;

	// scheduler state outside the ram
	logic [IW-1:0]        cur_q;
	logic [NUM_SLOTS-1:0] valid_q;

	// sweep address and the read in flight
	logic [IW-1:0] sweep_q;
	logic          s1_v_s1;
	logic [IW-1:0] s1_idx_s1;
	logic          s1_ent_valid_s1;

	// sweep findings
	logic          found_v_q;
	logic [IW-1:0] found_q;
	slot_st_t      qstate_q;

	// ram ports
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// entry processing for the returning read
	entry_t rd_ent;
	entry_t proc_ent;
	logic   proc_we;
	logic   cand;

	// resolve step
	logic          res_we;
	logic [IW-1:0] res_waddr;
	entry_t        res_wdata;
	logic          load_out;
	logic [IW-1:0] cur_d;
	logic [IW-1:0] res_idx;
	logic          res_sw;
	stat_t         res_stat;
	slot_st_t      res_sstate;
	logic          res_use_qs;

	// query range check
	logic [IW+QSLOT_W-1:0] qs_ext;
	logic                  qs_in_range;

	// output register
	logic                  out_v_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic                  out_sw_q;
	logic [STAT_W-1:0]     out_stat_q;
	logic [SSTATE_W-1:0]   out_sstate_q;
	logic [SLOT_OUT_W-1:0] out_cur_q;

	// slot numbers wider than the output field are masked to its width
	logic [IW+SLOT_OUT_W-1:0] res_idx_ext;
	logic [IW+SLOT_OUT_W-1:0] cur_d_ext;

	sts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign qs_ext      = (IW+QSLOT_W)'(qs_q);
	assign qs_in_range = (qs_q != '0) && (qs_ext < (IW+QSLOT_W)'(NUM_SLOTS));

	// an entry never written reads as empty with zero countdown
	assign rd_ent = s1_ent_valid_s1 ? entry_t'(ram_rdata) : '0;

	// per-entry update during a sweep
	always_comb begin
		proc_ent = rd_ent;
		proc_we  = 1'b0;
		cand     = 1'b0;
		if (s1_v_s1) begin
			unique case (req_q)
				REQ_TICK: begin
					if (rd_ent.st == SL_SLEEP) begin
						proc_we = 1'b1;
						if (rd_ent.left <= TICKS_W'(1)) begin
							proc_ent.st   = SL_READY;
							proc_ent.left = '0;
						end else begin
							proc_ent.left = rd_ent.left - TICKS_W'(1);
						end
					end
					// pick among slots after wake-up, never the current one
					cand = (proc_ent.st == SL_READY) && (s1_idx_s1 != cur_q);
				end
				REQ_CREATE: begin
					cand = (rd_ent.st == SL_EMPTY);
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer next state, ram control and result
	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = sweep_q;
		res_we     = 1'b0;
		res_waddr  = cur_q;
		res_wdata  = '0;
		load_out   = 1'b0;
		cur_d      = cur_q;
		res_idx    = '0;
		res_sw     = 1'b0;
		res_stat   = STAT_OK;
		res_sstate = SL_EMPTY;
		res_use_qs = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					priority if (req.req_type == REQ_TICK || req.req_type == REQ_CREATE) begin
						state_d = S_SWEEP;
					end else if (req.req_type == REQ_QUERY) begin
						state_d = S_QUERY;
					end else begin
						state_d = S_RESOLVE;
					end
				end
			end
			S_SWEEP: begin
				ram_re    = 1'b1;
				ram_raddr = sweep_q;
				if (sweep_q == IW'(NUM_SLOTS - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_QUERY: begin
				// out-of-range slots read anything; the result is masked
				ram_re    = 1'b1;
				ram_raddr = qs_ext[IW-1:0];
				state_d   = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_RESOLVE;
			end
			S_RESOLVE: begin
				load_out = !out_v_q || rsp.ready;
				unique case (req_q)
					REQ_TICK: begin
						if (found_v_q) begin
							cur_d  = found_q;
							res_sw = 1'b1;
						end
						res_idx = cur_d;
					end
					REQ_CREATE: begin
						if (found_v_q) begin
							res_we         = load_out;
							res_waddr      = found_q;
							res_wdata.st   = SL_READY;
							res_wdata.left = '0;
							res_idx        = found_q;
						end else begin
							res_stat = STAT_FULL;
						end
					end
					REQ_SLEEP, REQ_EXIT: begin
						if (cur_q == '0) begin
							res_stat = STAT_NOCUR;
						end else begin
							res_we    = load_out;
							res_waddr = cur_q;
							if (req_q == REQ_SLEEP) begin
								res_wdata.st   = SL_SLEEP;
								res_wdata.left = ticks_q;
							end
							res_idx = cur_q;
							cur_d   = '0;
						end
					end
					REQ_QUERY: begin
						res_use_qs = 1'b1;
						res_sstate = qstate_q;
					end
					default: begin
					end
				endcase
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// sweep write-back and resolve write never fall in the same cycle
		ram_we    = proc_we || res_we;
		ram_waddr = proc_we ? s1_idx_s1 : res_waddr;
		ram_wdata = proc_we ? proc_ent : res_wdata;
	end

	assign res_idx_ext = {{SLOT_OUT_W{1'b0}}, res_idx};
	assign cur_d_ext   = {{SLOT_OUT_W{1'b0}}, cur_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cur_q           <= '0;
			valid_q         <= '0;
			sweep_q         <= '0;
			s1_v_s1         <= 1'b0;
			s1_ent_valid_s1 <= 1'b0;
			found_v_q       <= 1'b0;
			out_v_q         <= 1'b0;
		end else begin
			state_q <= state_d;

			// capture request, restart sweep at slot 1
			if (state_q == S_IDLE && req.valid) begin
				sweep_q   <= IW'(1);
				found_v_q <= 1'b0;
			end else if (state_q == S_SWEEP) begin
				sweep_q <= sweep_q + IW'(1);
			end

			// read in flight
			s1_v_s1 <= ram_re;
			if (ram_re) begin
				s1_ent_valid_s1 <= valid_q[ram_raddr];
			end

			// first candidate of the sweep wins
			if (cand && !found_v_q) begin
				found_v_q <= 1'b1;
			end

			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end

			if (load_out) begin
				cur_q <= cur_d;
			end

			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			req_q   <= req.req_type;
			ticks_q <= req.sleep_ticks;
			qs_q    <= req.query_slot;
		end
		if (ram_re) begin
			s1_idx_s1 <= ram_raddr;
		end
		if (cand && !found_v_q) begin
			found_q <= s1_idx_s1;
		end
		if (s1_v_s1 && req_q == REQ_QUERY) begin
			qstate_q <= qs_in_range ? rd_ent.st : SL_EMPTY;
		end
		if (load_out) begin
			out_slot_q   <= res_use_qs ? qs_q : res_idx_ext[SLOT_OUT_W-1:0];
			out_sw_q     <= res_sw;
			out_stat_q   <= res_stat;
			out_sstate_q <= res_sstate;
			out_cur_q    <= cur_d_ext[SLOT_OUT_W-1:0];
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.result_slot = out_slot_q;
	assign rsp.switched    = out_sw_q;
	assign rsp.status      = out_stat_q;
	assign rsp.slot_state  = out_sstate_q;
	assign rsp.current_out = out_cur_q;

endmodule
